// ===== src/hkbm_pkg.sv =====
`default_nettype none

package hkbm_pkg;

    localparam int CODE_W      = 8;
    localparam int REPORT_KEYS = 6;
    localparam int BUTTON_W    = 10;
    localparam int MAP_MAX     = 10;
    localparam int MAP_LOW_N   = 8;
    localparam int PDATA_W     = 64;
    localparam int PADDR_W     = 4;
    localparam int MAP_HIGH_W  = 16;

    localparam int KEY_SLOTS_DEF   = 6;
    localparam int MAP_ENTRIES_DEF = 10;

    localparam logic [PDATA_W-1:0]    KEY_MAP_LOW_RST  = 64'h0D0F_0E0C_4F50_5152;
    localparam logic [MAP_HIGH_W-1:0] KEY_MAP_HIGH_RST = 16'h2A28;

    // register select, taken from paddr[3]
    typedef enum logic {
        REG_KEY_MAP_LOW  = 1'b0,
        REG_KEY_MAP_HIGH = 1'b1
    } reg_sel_t;

    typedef struct packed {
        logic load;      // capture a new report
        logic rel_all;   // drop every held key missing from the report
        logic press;     // handle one report position
        logic commit;    // report becomes the previous report
        logic out_load;  // move the button word to the output stage
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== src/hkbm_if.sv =====
`default_nettype none

interface hkbm_key_if;
    import hkbm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] key0;
    logic [CODE_W-1:0] key1;
    logic [CODE_W-1:0] key2;
    logic [CODE_W-1:0] key3;
    logic [CODE_W-1:0] key4;
    logic [CODE_W-1:0] key5;

    modport source (output valid, key0, key1, key2, key3, key4, key5, input ready);
    modport sink   (input valid, key0, key1, key2, key3, key4, key5, output ready);
endinterface

interface hkbm_btn_if;
    import hkbm_pkg::*;

    logic                valid;
    logic                ready;
    logic [BUTTON_W-1:0] buttons;

    modport source (output valid, buttons, input ready);
    modport sink   (input valid, buttons, output ready);
endinterface

`default_nettype wire

// ===== src/hkbm_cfg.sv =====
`default_nettype none

module hkbm_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [hkbm_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [hkbm_pkg::PDATA_W-1:0]      pwdata,
    output logic      [hkbm_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready,
    output logic      [hkbm_pkg::PDATA_W-1:0]      map_low,
    output logic      [hkbm_pkg::MAP_HIGH_W-1:0]   map_high
);
    import hkbm_pkg::*;

    logic [PDATA_W-1:0]    map_low_reg;
    logic [MAP_HIGH_W-1:0] map_high_reg;
    reg_sel_t              sel;
    logic                  wr_en;

    assign sel    = reg_sel_t'(paddr[3]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_low_reg  <= KEY_MAP_LOW_RST;
            map_high_reg <= KEY_MAP_HIGH_RST;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_KEY_MAP_LOW:  map_low_reg  <= pwdata;
                REG_KEY_MAP_HIGH: map_high_reg <= pwdata[MAP_HIGH_W-1:0];
                default:          map_low_reg  <= map_low_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_KEY_MAP_LOW:  prdata = map_low_reg;
            REG_KEY_MAP_HIGH: prdata = {{(PDATA_W-MAP_HIGH_W){1'b0}}, map_high_reg};
            default:          prdata = '0;
        endcase
    end

    assign map_low  = map_low_reg;
    assign map_high = map_high_reg;

endmodule

`default_nettype wire

// ===== src/hkbm_ctrl.sv =====
`default_nettype none

module hkbm_ctrl #(
    parameter int KEY_SLOTS = hkbm_pkg::KEY_SLOTS_DEF,
    parameter int IDX_W     = 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   out_free,
    output hkbm_pkg::dp_cmd_t           cmd,
    output logic      [IDX_W-1:0]       idx
);
    import hkbm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_REL   = 4'b0010,
        ST_PRESS = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(KEY_SLOTS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_REL;
                end
            end
            ST_REL:
            begin
                cmd.rel_all = 1'b1;
                idx_next    = '0;
                state_next  = ST_PRESS;
            end
            ST_PRESS:
            begin
                cmd.press = 1'b1;
                if (idx_reg == IDX_LAST)
                    state_next = ST_EMIT;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign idx = idx_reg;

endmodule

`default_nettype wire

// ===== src/hkbm_dp.sv =====
`default_nettype none

module hkbm_dp #(
    parameter int KEY_SLOTS   = hkbm_pkg::KEY_SLOTS_DEF,
    parameter int MAP_ENTRIES = hkbm_pkg::MAP_ENTRIES_DEF,
    parameter int IDX_W       = 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire hkbm_pkg::dp_cmd_t                cmd,
    input  wire logic [IDX_W-1:0]                 idx,
    input  wire logic [hkbm_pkg::CODE_W-1:0]      keys [hkbm_pkg::REPORT_KEYS],
    input  wire logic [hkbm_pkg::PDATA_W-1:0]     map_low,
    input  wire logic [hkbm_pkg::MAP_HIGH_W-1:0]  map_high,
    output logic      [hkbm_pkg::BUTTON_W-1:0]    buttons
);
    import hkbm_pkg::*;

    logic [CODE_W-1:0]   map_code [MAP_MAX];
    logic [CODE_W-1:0]   key_ext  [KEY_SLOTS];

    logic [CODE_W-1:0]   report_reg [KEY_SLOTS];
    logic [CODE_W-1:0]   report_next [KEY_SLOTS];
    logic [CODE_W-1:0]   prev_reg   [KEY_SLOTS];
    logic [CODE_W-1:0]   prev_next  [KEY_SLOTS];
    logic [CODE_W-1:0]   held_reg   [KEY_SLOTS];
    logic [CODE_W-1:0]   held_next  [KEY_SLOTS];
    logic [BUTTON_W-1:0] buttons_reg, buttons_next;

    logic [KEY_SLOTS-1:0] held_found;
    logic [KEY_SLOTS-1:0] rel_hit;
    logic [BUTTON_W-1:0]  clr_mask;
    logic [CODE_W-1:0]    press_code;
    logic                 in_prev;
    logic                 press_hit;
    logic                 free_any;
    logic [IDX_W-1:0]     free_idx;

    // split the map registers into one keycode per button
    for (genvar b = 0; b < MAP_MAX; b++)
    begin : g_map
        if (b < MAP_LOW_N)
        begin : g_low
            assign map_code[b] = map_low[CODE_W*b +: CODE_W];
        end
        else
        begin : g_high
            assign map_code[b] = map_high[CODE_W*(b-MAP_LOW_N) +: CODE_W];
        end
    end

    // report positions past the six input keys read as empty
    for (genvar i = 0; i < KEY_SLOTS; i++)
    begin : g_key
        if (i < REPORT_KEYS)
        begin : g_in
            assign key_ext[i] = keys[i];
        end
        else
        begin : g_pad
            assign key_ext[i] = '0;
        end
    end

    function automatic logic [BUTTON_W-1:0] match_vec(input logic [CODE_W-1:0] code);
        logic [BUTTON_W-1:0] m;
        m = '0;
        for (int b = 0; b < MAP_ENTRIES; b++)
            if (map_code[b] == code)
                m[b] = 1'b1;
        return m;
    endfunction

    // release: every held slot checked against the whole report at once
    always_comb
    begin
        clr_mask = '0;
        for (int s = 0; s < KEY_SLOTS; s++)
        begin
            held_found[s] = 1'b0;
            for (int r = 0; r < KEY_SLOTS; r++)
                if (report_reg[r] == held_reg[s])
                    held_found[s] = 1'b1;
            rel_hit[s] = (held_reg[s] != '0) && !held_found[s];
            if (rel_hit[s])
                clr_mask = clr_mask | match_vec(held_reg[s]);
        end
    end

    // press: one report position per step
    always_comb
    begin
        press_code = report_reg[idx];
        in_prev    = 1'b0;
        for (int k = 0; k < KEY_SLOTS; k++)
            if (prev_reg[k] == press_code)
                in_prev = 1'b1;
        press_hit = (press_code != '0) && !in_prev;

        free_any = 1'b0;
        free_idx = '0;
        for (int j = KEY_SLOTS - 1; j >= 0; j--)
        begin
            if (held_reg[j] == '0)
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(j);
            end
        end
    end

    always_comb
    begin
        report_next  = report_reg;
        prev_next    = prev_reg;
        held_next    = held_reg;
        buttons_next = buttons_reg;

        if (cmd.load)
            report_next = key_ext;

        if (cmd.rel_all)
        begin
            buttons_next = buttons_reg & ~clr_mask;
            for (int s = 0; s < KEY_SLOTS; s++)
                if (rel_hit[s])
                    held_next[s] = '0;
        end

        if (cmd.press && press_hit)
        begin
            buttons_next = buttons_reg | match_vec(press_code);
            if (free_any)
                held_next[free_idx] = press_code;
        end

        if (cmd.commit)
            prev_next = report_reg;
    end

    always_ff @(posedge clk)
    begin
        report_reg <= report_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < KEY_SLOTS; s++)
            begin
                prev_reg[s] <= '0;
                held_reg[s] <= '0;
            end
            buttons_reg <= '0;
        end
        else
        begin
            prev_reg    <= prev_next;
            held_reg    <= held_next;
            buttons_reg <= buttons_next;
        end
    end

    assign buttons = buttons_reg;

endmodule

`default_nettype wire

// ===== src/hkbm_out.sv =====
`default_nettype none

module hkbm_out (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire logic [hkbm_pkg::BUTTON_W-1:0]  din,
    output logic                                free,
    hkbm_btn_if.source                          dout
);
    import hkbm_pkg::*;

    logic                valid_reg;
    logic [BUTTON_W-1:0] data_reg;

    // slot may be refilled in the same cycle the sink takes the old word
    assign free = !valid_reg || dout.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (dout.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= din;
    end

    assign dout.valid   = valid_reg;
    assign dout.buttons = data_reg;

endmodule

`default_nettype wire

// ===== src/hid_keyboard_to_button_mapper_core.sv =====
`default_nettype none

// Channel       Dir   Payload             Handshake
// report        in    key0..key5 (8b ea)  valid/ready, word taken when both high
// button_word   out   buttons (10b)       valid/ready, word taken when both high
// APB cfg       in    key_map_low (64b) at 0x0, key_map_high (16b) at 0x8
//
// One report word runs through the states in order: accept, drop all released
// keys in parallel, one press step per report position (the shared press step
// walks them in order), then hand the button word to the output register. The
// press walk sets the length of a report.
// Reset clears held slots, the previous report and the button word; the key
// map returns to its default codes. A stalled output holds the controller in
// its emit state; the next report can be accepted while the last word waits.

module hid_keyboard_to_button_mapper_core #(
    parameter int KEY_SLOTS   = hkbm_pkg::KEY_SLOTS_DEF,
    parameter int MAP_ENTRIES = hkbm_pkg::MAP_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    hkbm_key_if.sink                           report,
    hkbm_btn_if.source                         button_word,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hkbm_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [hkbm_pkg::PDATA_W-1:0]  pwdata,
    output logic      [hkbm_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import hkbm_pkg::*;

    // slot index width; keep at least one bit for a single slot
    localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic [PDATA_W-1:0]    map_low;
    logic [MAP_HIGH_W-1:0] map_high;
    logic [CODE_W-1:0]     keys [REPORT_KEYS];
    logic [BUTTON_W-1:0]   buttons;
    logic [IDX_W-1:0]      idx;
    logic                  out_free;
    dp_cmd_t               cmd;

    // gather the report into an array for the datapath
    assign keys[0] = report.key0;
    assign keys[1] = report.key1;
    assign keys[2] = report.key2;
    assign keys[3] = report.key3;
    assign keys[4] = report.key4;
    assign keys[5] = report.key5;

    hkbm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .map_low  (map_low),
        .map_high (map_high)
    );

    // sequencer: accept, release, press walk, emit
    hkbm_ctrl #(
        .KEY_SLOTS (KEY_SLOTS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (report.valid),
        .in_ready (report.ready),
        .out_free (out_free),
        .cmd      (cmd),
        .idx      (idx)
    );

    // held slots, previous report and button word
    hkbm_dp #(
        .KEY_SLOTS   (KEY_SLOTS),
        .MAP_ENTRIES (MAP_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .idx      (idx),
        .keys     (keys),
        .map_low  (map_low),
        .map_high (map_high),
        .buttons  (buttons)
    );

    // output register parts the sink from the sequencer
    hkbm_out u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.out_load),
        .din   (buttons),
        .free  (out_free),
        .dout  (button_word)
    );

endmodule

`default_nettype wire
